@@ hw/rtl/mmtrs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Model matrix package
// Shared types, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package mmtrs_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int AtanLen          = 24;

    // pi/180 in Q32 and the CORDIC gain in Q30.
    localparam logic [26:0] Deg2RadQ32   = 27'd74961321;
    localparam logic [31:0] CordicGainQ30 = 32'd652032874;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] rot_x_deg;
        logic signed [31:0] rot_y_deg;
        logic signed [31:0] rot_z_deg;
        logic signed [31:0] scl_x;
        logic signed [31:0] scl_y;
        logic signed [31:0] scl_z;
    } trs_in_t;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m03;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m13;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
        logic signed [31:0] m23;
    } mat_out_t;

    // Sine, cosine and angle residue of one angle in the CORDIC chain (Q30).
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               neg;
    } rot_lane_t;

    // Arctangent of 2^-i in Q30, truncated.
    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic signed [33:0] r;
        unique case (i)
            5'd0:  r = 34'sd843314856;
            5'd1:  r = 34'sd497837829;
            5'd2:  r = 34'sd263043836;
            5'd3:  r = 34'sd133525158;
            5'd4:  r = 34'sd67021686;
            5'd5:  r = 34'sd33543515;
            5'd6:  r = 34'sd16775850;
            5'd7:  r = 34'sd8388437;
            5'd8:  r = 34'sd4194282;
            5'd9:  r = 34'sd2097149;
            5'd10: r = 34'sd1048575;
            5'd11: r = 34'sd524287;
            5'd12: r = 34'sd262143;
            5'd13: r = 34'sd131071;
            5'd14: r = 34'sd65535;
            5'd15: r = 34'sd32767;
            5'd16: r = 34'sd16383;
            5'd17: r = 34'sd8191;
            5'd18: r = 34'sd4095;
            5'd19: r = 34'sd2047;
            5'd20: r = 34'sd1023;
            5'd21: r = 34'sd511;
            5'd22: r = 34'sd255;
            5'd23: r = 34'sd127;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/mmtrs_angle_prep.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Angle preparation
// Wraps one angle into [-90,90] degrees and converts it to Q30 radians
// over three registered stages.
// ----------------------------------------------------------------------------
module mmtrs_angle_prep #(
    parameter int FRAC_BITS = mmtrs_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic signed [31:0] deg,
    output mmtrs_pkg::rot_lane_t    lane
);
    import mmtrs_pkg::*;

    localparam logic signed [41:0] Full = 42'sd360 <<< FRAC_BITS;
    localparam logic signed [41:0] Half = 42'sd180 <<< FRAC_BITS;
    localparam logic signed [41:0] Quar = 42'sd90  <<< FRAC_BITS;
    localparam int                 Sh   = FRAC_BITS + 2;
    localparam int                 Sh1  = FRAC_BITS + 3;
    // floor(2^24 / 45), the reciprocal used for the quotient estimate.
    localparam logic signed [55:0] Recip45 = 56'sd372827;

    // Stage 1: floor remainder by 360 degrees. Since 360<<F is 45<<(F+3),
    // the bits above F+3 are reduced modulo 45 through a reciprocal
    // estimate that is low by at most one, then a single correction.
    logic signed [41:0] rem_reg, rem_next;
    logic signed [31:0] hi, q_est, r0, r1;
    logic signed [55:0] qm;

    always_comb
    begin
        hi    = deg >>> Sh1;
        qm    = 56'(hi) * Recip45;
        q_est = 32'(qm >>> 24);
        r0    = hi - 32'(q_est * 32'sd45);
        r1    = (r0 >= 32'sd45) ? r0 - 32'sd45 : r0;
        rem_next = (42'(r1) <<< Sh1) | 42'(deg[Sh1-1:0]);
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

    // Stage 2: fold into [-90,90] and take the magnitude.
    logic signed [41:0] w;
    logic        [31:0] mag_reg, mag_next;
    logic               minus_reg, minus_next, neg_reg, neg_next;

    always_comb
    begin
        w = rem_reg;
        neg_next = 1'b0;
        if (w < 0)
        begin
            w = w + Full;
        end
        if (w >= Half)
        begin
            w = w - Full;
        end
        if (w > Quar)
        begin
            w = w - Half;
            neg_next = 1'b1;
        end
        else if (w < -Quar)
        begin
            w = w + Half;
            neg_next = 1'b1;
        end
        minus_next = w[41];
        mag_next   = minus_next ? 32'(-w) : 32'(w);
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        minus_reg <= minus_next;
        neg_reg   <= neg_next;
    end

    // Stage 3: multiply by pi/180 and round to Q30.
    logic [58:0] prod;
    logic [58:0] rad;
    rot_lane_t   lane_reg, lane_next;

    always_comb
    begin
        prod = 59'(mag_reg) * 59'(Deg2RadQ32);
        rad  = (prod + (59'd1 << (Sh - 1))) >> Sh;
        lane_next.x   = 34'(CordicGainQ30);
        lane_next.y   = '0;
        lane_next.z   = minus_reg ? -$signed(34'(rad)) : $signed(34'(rad));
        lane_next.neg = neg_reg;
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign lane = lane_reg;

endmodule
`default_nettype wire

@@ hw/rtl/mmtrs_cordic_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CORDIC cell
// One rotation step for the three angle lanes, registered, handing the
// lanes to the next cell.
// ----------------------------------------------------------------------------
module mmtrs_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire logic                       clk,
    input  wire mmtrs_pkg::rot_lane_t [2:0] lane_in,
    output mmtrs_pkg::rot_lane_t [2:0]      lane_out
);
    import mmtrs_pkg::*;

    localparam logic [4:0] Idx = 5'(STEP);

    rot_lane_t [2:0] lane_reg, lane_next;

    // Rotate toward zero residue; shifts are arithmetic (floor).
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lane_next[k].neg = lane_in[k].neg;
            if (!lane_in[k].z[33])
            begin
                lane_next[k].x = lane_in[k].x - (lane_in[k].y >>> STEP);
                lane_next[k].y = lane_in[k].y + (lane_in[k].x >>> STEP);
                lane_next[k].z = lane_in[k].z - atan_q30(Idx);
            end
            else
            begin
                lane_next[k].x = lane_in[k].x + (lane_in[k].y >>> STEP);
                lane_next[k].y = lane_in[k].y - (lane_in[k].x >>> STEP);
                lane_next[k].z = lane_in[k].z + atan_q30(Idx);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign lane_out = lane_reg;

endmodule
`default_nettype wire

@@ hw/rtl/mmtrs_matrix_build.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix build
// Forms the rotation products from sines and cosines and applies the scale
// with saturation, one multiply level per registered stage.
// ----------------------------------------------------------------------------
module mmtrs_matrix_build (
    input  wire logic                  clk,
    input  wire logic signed [33:0]    sx,
    input  wire logic signed [33:0]    cx,
    input  wire logic signed [33:0]    sy,
    input  wire logic signed [33:0]    cy,
    input  wire logic signed [33:0]    sz,
    input  wire logic signed [33:0]    cz,
    input  wire logic signed [31:0]    scl_x,
    input  wire logic signed [31:0]    scl_y,
    input  wire logic signed [31:0]    scl_z,
    input  wire logic signed [31:0]    pos_x,
    input  wire logic signed [31:0]    pos_y,
    input  wire logic signed [31:0]    pos_z,
    output mmtrs_pkg::mat_out_t        mat
);
    import mmtrs_pkg::*;

    // Q30 product rounded back to Q30.
    function automatic logic signed [33:0] rnd30(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
        logic signed [67:0] p;
        p = (68'(a) * 68'(b)) + 68'sd536870912;
        return 34'(p >>> 30);
    endfunction

    function automatic logic signed [31:0] sat_scale(input logic signed [33:0] r,
                                                     input logic signed [31:0] s);
        logic signed [65:0] p;
        logic signed [35:0] e;
        p = (66'(r) * 66'(s)) + 66'sd536870912;
        e = 36'(p >>> 30);
        if (e > 36'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (e < -36'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return 32'(e);
    endfunction

    // Stage A: pair products.
    logic signed [33:0] sxsy_reg, cxsy_reg, cycz_reg, cysz_reg, cxsz_reg, cxcz_reg;
    logic signed [33:0] sxcy_reg, sxsz_reg, sxcz_reg, cxcy_reg;
    logic signed [33:0] a_sy_reg, a_cz_reg, a_sz_reg;
    logic signed [31:0] a_scl_reg [3];
    logic signed [31:0] a_pos_reg [3];

    always_ff @(posedge clk)
    begin
        sxsy_reg <= rnd30(sx, sy);
        cxsy_reg <= rnd30(cx, sy);
        cycz_reg <= rnd30(cy, cz);
        cysz_reg <= rnd30(cy, sz);
        cxsz_reg <= rnd30(cx, sz);
        cxcz_reg <= rnd30(cx, cz);
        sxcy_reg <= rnd30(sx, cy);
        sxsz_reg <= rnd30(sx, sz);
        sxcz_reg <= rnd30(sx, cz);
        cxcy_reg <= rnd30(cx, cy);
        a_sy_reg <= sy;
        a_cz_reg <= cz;
        a_sz_reg <= sz;
        a_scl_reg[0] <= scl_x;
        a_scl_reg[1] <= scl_y;
        a_scl_reg[2] <= scl_z;
        a_pos_reg[0] <= pos_x;
        a_pos_reg[1] <= pos_y;
        a_pos_reg[2] <= pos_z;
    end

    // Stage B: triple products and the rotation elements.
    logic signed [33:0] r_reg [3][3];
    logic signed [31:0] b_scl_reg [3];
    logic signed [31:0] b_pos_reg [3];

    always_ff @(posedge clk)
    begin
        r_reg[0][0] <= cycz_reg;
        r_reg[0][1] <= -cysz_reg;
        r_reg[0][2] <= a_sy_reg;
        r_reg[1][0] <= rnd30(sxsy_reg, a_cz_reg) + cxsz_reg;
        r_reg[1][1] <= cxcz_reg - rnd30(sxsy_reg, a_sz_reg);
        r_reg[1][2] <= -sxcy_reg;
        r_reg[2][0] <= sxsz_reg - rnd30(cxsy_reg, a_cz_reg);
        r_reg[2][1] <= rnd30(cxsy_reg, a_sz_reg) + sxcz_reg;
        r_reg[2][2] <= cxcy_reg;
        b_scl_reg <= a_scl_reg;
        b_pos_reg <= a_pos_reg;
    end

    // Stage C: scale each column and saturate.
    mat_out_t mat_reg, mat_next;

    always_comb
    begin
        mat_next.m00 = sat_scale(r_reg[0][0], b_scl_reg[0]);
        mat_next.m01 = sat_scale(r_reg[0][1], b_scl_reg[1]);
        mat_next.m02 = sat_scale(r_reg[0][2], b_scl_reg[2]);
        mat_next.m03 = b_pos_reg[0];
        mat_next.m10 = sat_scale(r_reg[1][0], b_scl_reg[0]);
        mat_next.m11 = sat_scale(r_reg[1][1], b_scl_reg[1]);
        mat_next.m12 = sat_scale(r_reg[1][2], b_scl_reg[2]);
        mat_next.m13 = b_pos_reg[1];
        mat_next.m20 = sat_scale(r_reg[2][0], b_scl_reg[0]);
        mat_next.m21 = sat_scale(r_reg[2][1], b_scl_reg[1]);
        mat_next.m22 = sat_scale(r_reg[2][2], b_scl_reg[2]);
        mat_next.m23 = b_pos_reg[2];
    end

    always_ff @(posedge clk)
    begin
        mat_reg <= mat_next;
    end

    assign mat = mat_reg;

endmodule
`default_nettype wire

@@ hw/rtl/model_matrix_from_trs_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Model matrix from translation, rotation and scale
// Builds the upper three rows of T * Rx * Ry * Rz * S for one transform.
//
// Channel   Signals              Direction  Meaning
// input     start, busy, trs     in         one transform item
// result    done, mat            out        one matrix item, one cycle
//
// One item may start every cycle; busy stays low.
// An item passes through angle preparation, the chain of CORDIC cells
// (one per step), then product, combine and scale stages.
// Reset clears only the valid pipeline; data registers are not reset.
// The receiver cannot stall, so done is a single-cycle strobe.
// ----------------------------------------------------------------------------
module model_matrix_from_trs_core #(
    parameter int FRAC_BITS    = mmtrs_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = mmtrs_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire mmtrs_pkg::trs_in_t trs,
    output logic                    done,
    output mmtrs_pkg::mat_out_t     mat
);
    import mmtrs_pkg::*;

    localparam int Latency = 3 + CORDIC_STEPS + 3;
    localparam int Lead    = 3 + CORDIC_STEPS;

    assign busy = 1'b0;

    // Valid pipeline.
    logic [Latency-1:0] vld_reg, vld_next;

    always_comb
    begin
        vld_next = {vld_reg[Latency-2:0], start};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Scale and translation ride alongside the angle path.
    trs_in_t side_reg [Lead];

    always_ff @(posedge clk)
    begin
        side_reg[0] <= trs;
        for (int k = 1; k < Lead; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    // Angle preparation for the three axes.
    rot_lane_t [2:0] chain [CORDIC_STEPS+1];

    mmtrs_angle_prep #(.FRAC_BITS(FRAC_BITS)) u_prep_x
        (.clk(clk), .deg(trs.rot_x_deg), .lane(chain[0][0]));
    mmtrs_angle_prep #(.FRAC_BITS(FRAC_BITS)) u_prep_y
        (.clk(clk), .deg(trs.rot_y_deg), .lane(chain[0][1]));
    mmtrs_angle_prep #(.FRAC_BITS(FRAC_BITS)) u_prep_z
        (.clk(clk), .deg(trs.rot_z_deg), .lane(chain[0][2]));

    // Chain of CORDIC cells.
    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cell
        mmtrs_cordic_cell #(.STEP(g)) u_cell
            (.clk(clk), .lane_in(chain[g]), .lane_out(chain[g+1]));
    end

    // Apply the fold negation.
    logic signed [33:0] s_v [3];
    logic signed [33:0] c_v [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s_v[k] = chain[CORDIC_STEPS][k].neg ? -chain[CORDIC_STEPS][k].y
                                                :  chain[CORDIC_STEPS][k].y;
            c_v[k] = chain[CORDIC_STEPS][k].neg ? -chain[CORDIC_STEPS][k].x
                                                :  chain[CORDIC_STEPS][k].x;
        end
    end

    mmtrs_matrix_build u_build (
        .clk(clk),
        .sx(s_v[0]), .cx(c_v[0]),
        .sy(s_v[1]), .cy(c_v[1]),
        .sz(s_v[2]), .cz(c_v[2]),
        .scl_x(side_reg[Lead-1].scl_x),
        .scl_y(side_reg[Lead-1].scl_y),
        .scl_z(side_reg[Lead-1].scl_z),
        .pos_x(side_reg[Lead-1].pos_x),
        .pos_y(side_reg[Lead-1].pos_y),
        .pos_z(side_reg[Lead-1].pos_z),
        .mat(mat)
    );

    assign done = vld_reg[Latency-1];

endmodule
`default_nettype wire

@@ hw/rtl/mmtrs_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Port checker
// Watches the top-level ports for item count and latency.
// ----------------------------------------------------------------------------
module mmtrs_port_assert #(
    parameter int CORDIC_STEPS = mmtrs_pkg::CORDIC_STEPS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done
);
    // The block never refuses an item.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // A result follows each item after a fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(6 + CORDIC_STEPS) done)
        else $error("result missing");

    // No result without an item at the matching earlier edge.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 6 + CORDIC_STEPS))
        else $error("unexpected result");

endmodule

bind model_matrix_from_trs_core mmtrs_port_assert #(.CORDIC_STEPS(CORDIC_STEPS)) u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done)
);
`default_nettype wire

@@ sim/mmtrs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Model matrix checker
// Watches the transform and matrix channels of the model matrix core. It
// predicts each matrix in fixed point and compares it field by field.
// ----------------------------------------------------------------------------
module mmtrs_checker
    import mmtrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  trs_in_t   trs,
    input  logic      done,
    input  mat_out_t  mat,
    output int        fail_count,
    output int        pending
);

    localparam int FB    = FRAC_BITS_DEF;
    localparam int STEPS = CORDIC_STEPS_DEF;

    mat_out_t matrix_queue[$];

    // Floor shift of a signed value; >>> on a signed longint is arithmetic.
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_q30(longint p);
        return floor_shr(p + (64'sd1 <<< 29), 30);
    endfunction

    // Sine and cosine of an angle in degrees, both in Q30.
    function automatic void angle_sincos(input logic signed [31:0] deg,
                                         output longint s_q30, output longint c_q30);
        longint one_deg;
        longint full;
        longint w;
        longint mag;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        bit     minus;
        one_deg = 64'sd1 <<< FB;
        full = 360 * one_deg;
        w = longint'(deg) % full;
        flip = 0;
        if (w < 0)
            w += full;
        if (w >= 180 * one_deg)
            w -= full;
        // Fold into [-90, 90]; the fold negates sine and cosine.
        if (w > 90 * one_deg)
        begin
            w -= 180 * one_deg;
            flip = 1;
        end
        else if (w < -90 * one_deg)
        begin
            w += 180 * one_deg;
            flip = 1;
        end
        minus = (w < 0);
        mag = minus ? -w : w;
        mag = (mag * longint'(Deg2RadQ32) + (64'sd1 <<< (FB + 1))) >>> (FB + 2);
        z = minus ? -mag : mag;
        x = longint'(CordicGainQ30);
        y = 0;
        for (int i = 0; i < STEPS && i < AtanLen; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(atan_q30(i[4:0]));
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(atan_q30(i[4:0]));
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        s_q30 = y;
        c_q30 = x;
    endfunction

    function automatic logic signed [31:0] scale_elem(longint r, logic signed [31:0] s);
        longint e;
        e = round_q30(r * longint'(s));
        if (e > 64'sd2147483647)
            e = 64'sd2147483647;
        if (e < -64'sd2147483648)
            e = -64'sd2147483648;
        return e[31:0];
    endfunction

    // Predict the matrix for one transform.
    function automatic mat_out_t predict_matrix(trs_in_t t);
        longint   sx;
        longint   cx;
        longint   sy;
        longint   cy;
        longint   sz;
        longint   cz;
        longint   sxsy;
        longint   cxsy;
        longint   r[3][3];
        mat_out_t m;
        angle_sincos(t.rot_x_deg, sx, cx);
        angle_sincos(t.rot_y_deg, sy, cy);
        angle_sincos(t.rot_z_deg, sz, cz);
        sxsy = round_q30(sx * sy);
        cxsy = round_q30(cx * sy);
        r[0][0] = round_q30(cy * cz);
        r[0][1] = -round_q30(cy * sz);
        r[0][2] = sy;
        r[1][0] = round_q30(sxsy * cz) + round_q30(cx * sz);
        r[1][1] = round_q30(cx * cz) - round_q30(sxsy * sz);
        r[1][2] = -round_q30(sx * cy);
        r[2][0] = round_q30(sx * sz) - round_q30(cxsy * cz);
        r[2][1] = round_q30(cxsy * sz) + round_q30(sx * cz);
        r[2][2] = round_q30(cx * cy);
        m.m00 = scale_elem(r[0][0], t.scl_x);
        m.m01 = scale_elem(r[0][1], t.scl_y);
        m.m02 = scale_elem(r[0][2], t.scl_z);
        m.m03 = t.pos_x;
        m.m10 = scale_elem(r[1][0], t.scl_x);
        m.m11 = scale_elem(r[1][1], t.scl_y);
        m.m12 = scale_elem(r[1][2], t.scl_z);
        m.m13 = t.pos_y;
        m.m20 = scale_elem(r[2][0], t.scl_x);
        m.m21 = scale_elem(r[2][1], t.scl_y);
        m.m22 = scale_elem(r[2][2], t.scl_z);
        m.m23 = t.pos_z;
        return m;
    endfunction

    task automatic compare_field(string name, logic signed [31:0] exp_v,
                                 logic signed [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    // Record accepted transforms and check each matrix against the oldest one.
    always @(posedge clk)
    begin
        mat_out_t e;
        if (rst_n)
        begin
            if (start && !busy)
                matrix_queue.push_back(predict_matrix(trs));
            if (done)
            begin
                if (matrix_queue.size() == 0)
                begin
                    $display("%0t: matrix item with none expected, actual %h", $time, mat);
                    fail_count++;
                end
                else
                begin
                    e = matrix_queue.pop_front();
                    compare_field("m00", e.m00, mat.m00);
                    compare_field("m01", e.m01, mat.m01);
                    compare_field("m02", e.m02, mat.m02);
                    compare_field("m03", e.m03, mat.m03);
                    compare_field("m10", e.m10, mat.m10);
                    compare_field("m11", e.m11, mat.m11);
                    compare_field("m12", e.m12, mat.m12);
                    compare_field("m13", e.m13, mat.m13);
                    compare_field("m20", e.m20, mat.m20);
                    compare_field("m21", e.m21, mat.m21);
                    compare_field("m22", e.m22, mat.m22);
                    compare_field("m23", e.m23, mat.m23);
                end
            end
        end
        pending = matrix_queue.size();
    end

endmodule

@@ sim/model_matrix_from_trs_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Model matrix core test
// Drives directed and random transforms with random gaps into the core and
// gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module model_matrix_from_trs_core_test;
    import mmtrs_pkg::*;

    localparam int LATENCY    = 3 + CORDIC_STEPS_DEF + 3;
    localparam int RAND_ITEMS = 1650;
    localparam int CYCLE_CAP  = 400000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    trs_in_t  trs;
    logic     done;
    mat_out_t mat;
    int       fail_count;
    int       pending;
    int       cycles;

    model_matrix_from_trs_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .trs   (trs),
        .done  (done),
        .mat   (mat)
    );

    mmtrs_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .trs        (trs),
        .done       (done),
        .mat        (mat),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 0;
    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    // Run limit well above the slowest correct run.
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_word();
        return $urandom;
    endfunction

    // Angle in degrees: exact multiples of 90, near ones, small or any pattern.
    function automatic logic signed [31:0] rand_angle();
        int k;
        k = $urandom_range(0, 9);
        if (k < 2)
            return ($signed($urandom_range(0, 16)) - 8) * (90 <<< 16);
        else if (k < 4)
            return ($signed($urandom_range(0, 8)) - 4) * (90 <<< 16)
                   + $signed($urandom_range(0, 8)) - 4;
        else if (k < 8)
            return $signed($urandom_range(0, 1440 <<< 16)) - (720 <<< 16);
        return rand_word();
    endfunction

    // Scale: mostly moderate, sometimes huge to force saturation.
    function automatic logic signed [31:0] rand_scale();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6)
            return $signed($urandom_range(0, 8 <<< 16)) - (4 <<< 16);
        return rand_word();
    endfunction

    // Present one item and hold it until accepted.
    task automatic send_item(trs_in_t t);
        start <= 1'b1;
        trs   <= t;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic idle_gap();
        int n;
        int k;
        k = $urandom_range(0, 19);
        if (k < 10)
            n = 0;
        else if (k < 18)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(10, 40);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic trs_in_t make_item(logic signed [31:0] p, logic signed [31:0] a,
                                          logic signed [31:0] s);
        trs_in_t t;
        t.pos_x = p;
        t.pos_y = ~p;
        t.pos_z = p ^ 32'h5a5a_a5a5;
        t.rot_x_deg = a;
        t.rot_y_deg = a;
        t.rot_z_deg = a;
        t.scl_x = s;
        t.scl_y = s;
        t.scl_z = s;
        return t;
    endfunction

    initial
    begin
        trs_in_t t;
        logic signed [31:0] dir_angle[12];
        rst_n = 0;
        start = 0;
        trs = '0;
        dir_angle = '{0, 90 <<< 16, -(90 <<< 16), 180 <<< 16, -(180 <<< 16),
                      360 <<< 16, 32'h7fff_ffff, 32'h8000_0000, 45 <<< 16,
                      (90 <<< 16) + 1, 270 <<< 16, -1};
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: angle extremes and folds, unit scale, extreme fields.
        foreach (dir_angle[i])
            send_item(make_item(dir_angle[i] ^ 32'h0001_2345, dir_angle[i], 32'sh0001_0000));
        send_item(make_item(32'h7fff_ffff, 0, 32'h7fff_ffff));
        send_item(make_item(32'h8000_0000, 0, 32'h8000_0000));
        send_item(make_item(0, 45 <<< 16, 32'h7fff_ffff));
        send_item(make_item(-1, 135 <<< 16, 32'h8000_0000));
        send_item(make_item(32'hffff_ffff, 30 <<< 16, 0));
        send_item(make_item(1, -(30 <<< 16), -(32'sh0001_0000)));

        // Pause until the pipeline has drained.
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);

        // Random transforms.
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            t.pos_x = rand_word();
            t.pos_y = rand_word();
            t.pos_z = rand_word();
            t.rot_x_deg = rand_angle();
            t.rot_y_deg = rand_angle();
            t.rot_z_deg = rand_angle();
            t.scl_x = rand_scale();
            t.scl_y = rand_scale();
            t.scl_z = rand_scale();
            send_item(t);
            idle_gap();
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
